/* hw/rtl/aopq_pkg.sv */
// shared types and constants of the open-list priority queue
// no dependencies
package aopq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int COST_BITS   = 10;
    localparam int HANDLE_BITS = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STATUS_W    = 2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [COST_BITS-1:0]   f;
        logic [COST_BITS-1:0]   h;
    } entry_t;

    typedef enum logic [1:0] {
        RES_INSERT,
        RES_FULL,
        RES_EMPTY,
        RES_POP
    } res_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CMP,
        S_POP_RD,
        S_POP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic      capture;
        logic      rd_prev;
        logic      shift;
        logic      place;
        logic      rd_head;
        logic      pop;
        logic      load_res;
        res_kind_t res_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic cmd_pop;
        logic full;
        logic empty;
        logic scan_zero;
        logic goes_before;
        logic out_free;
    } dp_stat_t;

endpackage

/* hw/rtl/aopq_in_if.sv */
// request channel of the open-list priority queue
// depends on aopq_pkg
interface aopq_in_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [aopq_pkg::HANDLE_BITS-1:0] entry_handle;
    logic [aopq_pkg::COST_BITS-1:0]   total_cost;
    logic [aopq_pkg::COST_BITS-1:0]   heuristic_cost;

    modport source (output valid, cmd, entry_handle, total_cost, heuristic_cost, input ready);
    modport sink (input valid, cmd, entry_handle, total_cost, heuristic_cost, output ready);
endinterface

/* hw/rtl/aopq_out_if.sv */
// result channel of the open-list priority queue
// depends on aopq_pkg
interface aopq_out_if;
    logic                             valid;
    logic                             ready;
    logic [aopq_pkg::STATUS_W-1:0]    status;
    logic [aopq_pkg::HANDLE_BITS-1:0] out_handle;
    logic [aopq_pkg::COST_BITS-1:0]   out_total_cost;
    logic [aopq_pkg::COST_BITS-1:0]   out_heuristic;
    logic [aopq_pkg::CNT_W-1:0]       occupancy;

    modport source (output valid, status, out_handle, out_total_cost, out_heuristic,
                    occupancy, input ready);
    modport sink (input valid, status, out_handle, out_total_cost, out_heuristic,
                  occupancy, output ready);
endinterface

/* hw/rtl/astar_open_list_priority_queue.sv */
// top level of the open-list priority queue: sequencer plus datapath
// depends on aopq_pkg, aopq_in_if, aopq_out_if, aopq_ctrl, aopq_datapath
//
//  channel | dir | word
//  req     | in  | cmd, entry_handle, total_cost, heuristic_cost
//  rsp     | out | status, out_handle, out_total_cost, out_heuristic, occupancy
//
// a pop reads the head entry and then advances the head; an insert walks from the tail toward
// the head, moving each entry that the new word goes before down by one slot, and places the
// word where the walk stops; a pop on empty and an insert into a full store go straight to
// the result, the entry ring having a single read and a single write port
// one word is worked at a time; the next is taken once the result sits in the output register
// a stalled result holds the block only when a second result is ready behind it
// reset empties the store at once; the entry ring needs no clearing
module astar_open_list_priority_queue (
    input logic       clk,
    input logic       rst_n,
    aopq_in_if.sink   req,
    aopq_out_if.source rsp
);

    aopq_pkg::dp_cmd_t  dp_cmd;
    aopq_pkg::dp_stat_t dp_stat;

    aopq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    aopq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .in_cmd     (req.cmd),
        .in_handle  (req.entry_handle),
        .in_f       (req.total_cost),
        .in_h       (req.heuristic_cost),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_status (rsp.status),
        .rsp_handle (rsp.out_handle),
        .rsp_f      (rsp.out_total_cost),
        .rsp_h      (rsp.out_heuristic),
        .rsp_occ    (rsp.occupancy)
    );

endmodule

/* hw/rtl/aopq_ctrl.sv */
// sequencer of the open-list priority queue: insert scan, pop and result hand-off
// depends on aopq_pkg
module aopq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  aopq_pkg::dp_stat_t stat,
    output aopq_pkg::dp_cmd_t  cmd
);

    aopq_pkg::state_t    state_reg, state_next;
    aopq_pkg::res_kind_t kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aopq_pkg::S_IDLE;
            kind_reg  <= aopq_pkg::RES_INSERT;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        case (state_reg)
            aopq_pkg::S_IDLE:
            begin
                if (req_valid)
                    state_next = aopq_pkg::S_DECODE;
            end
            aopq_pkg::S_DECODE:
            begin
                if (stat.cmd_pop)
                begin
                    if (stat.empty)
                    begin
                        kind_next  = aopq_pkg::RES_EMPTY;
                        state_next = aopq_pkg::S_FINISH;
                    end
                    else
                    begin
                        kind_next  = aopq_pkg::RES_POP;
                        state_next = aopq_pkg::S_POP_RD;
                    end
                end
                else if (stat.full)
                begin
                    kind_next  = aopq_pkg::RES_FULL;
                    state_next = aopq_pkg::S_FINISH;
                end
                else
                begin
                    kind_next  = aopq_pkg::RES_INSERT;
                    state_next = aopq_pkg::S_SCAN;
                end
            end
            aopq_pkg::S_SCAN:
            begin
                if (stat.scan_zero)
                    state_next = aopq_pkg::S_FINISH;
                else
                    state_next = aopq_pkg::S_CMP;
            end
            aopq_pkg::S_CMP:
            begin
                if (stat.goes_before)
                    state_next = aopq_pkg::S_SCAN;
                else
                    state_next = aopq_pkg::S_FINISH;
            end
            aopq_pkg::S_POP_RD: state_next = aopq_pkg::S_POP;
            aopq_pkg::S_POP:    state_next = aopq_pkg::S_FINISH;
            aopq_pkg::S_FINISH:
            begin
                if (stat.out_free)
                    state_next = aopq_pkg::S_IDLE;
            end
            default: state_next = aopq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.res_kind = kind_reg;
        req_ready    = 1'b0;
        case (state_reg)
            aopq_pkg::S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            aopq_pkg::S_SCAN:
            begin
                if (stat.scan_zero)
                    cmd.place = 1'b1;
                else
                    cmd.rd_prev = 1'b1;
            end
            aopq_pkg::S_CMP:
            begin
                if (stat.goes_before)
                    cmd.shift = 1'b1;
                else
                    cmd.place = 1'b1;
            end
            aopq_pkg::S_POP_RD: cmd.rd_head  = 1'b1;
            aopq_pkg::S_POP:    cmd.pop      = 1'b1;
            aopq_pkg::S_FINISH: cmd.load_res = stat.out_free;
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> state_reg == aopq_pkg::S_IDLE)
        else $error("ready outside idle");
    a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> state_reg == aopq_pkg::S_DECODE)
        else $error("accepted word not decoded");
    a_pop_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> $past(cmd.rd_head))
        else $error("pop without head read");
`endif

endmodule

/* hw/rtl/aopq_datapath.sv */
// storage ring, sort compare and result register of the open-list priority queue
// depends on aopq_pkg
module aopq_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  aopq_pkg::dp_cmd_t                cmd,
    output aopq_pkg::dp_stat_t               stat,
    input  logic                             in_cmd,
    input  logic [aopq_pkg::HANDLE_BITS-1:0] in_handle,
    input  logic [aopq_pkg::COST_BITS-1:0]   in_f,
    input  logic [aopq_pkg::COST_BITS-1:0]   in_h,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic [aopq_pkg::STATUS_W-1:0]    rsp_status,
    output logic [aopq_pkg::HANDLE_BITS-1:0] rsp_handle,
    output logic [aopq_pkg::COST_BITS-1:0]   rsp_f,
    output logic [aopq_pkg::COST_BITS-1:0]   rsp_h,
    output logic [aopq_pkg::CNT_W-1:0]       rsp_occ
);

    aopq_pkg::entry_t mem [aopq_pkg::QUEUE_DEPTH];

    aopq_pkg::entry_t             cur_reg;
    logic                         cmd_reg;
    aopq_pkg::entry_t             rd_data_reg;
    aopq_pkg::entry_t             pop_reg;
    logic [aopq_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [aopq_pkg::PTR_W-1:0]   head_reg, head_next;
    logic [aopq_pkg::CNT_W-1:0]   scan_reg;
    logic                         out_valid_reg, out_valid_next;
    aopq_pkg::status_t            out_status_reg;
    aopq_pkg::entry_t             out_entry_reg;
    logic [aopq_pkg::CNT_W-1:0]   out_occ_reg;

    logic [aopq_pkg::PTR_W-1:0]   wr_addr;
    logic [aopq_pkg::PTR_W-1:0]   prev_addr;
    logic [aopq_pkg::CNT_W-1:0]   scan_dec;

    // ring addressing from the head
    assign scan_dec  = scan_reg - aopq_pkg::CNT_W'(1);
    assign wr_addr   = head_reg + scan_reg[aopq_pkg::PTR_W-1:0];
    assign prev_addr = head_reg + scan_dec[aopq_pkg::PTR_W-1:0];

    always_comb
    begin
        stat.cmd_pop     = (cmd_reg == aopq_pkg::CMD_POP);
        stat.full        = (count_reg == aopq_pkg::CNT_W'(aopq_pkg::QUEUE_DEPTH));
        stat.empty       = (count_reg == '0);
        stat.scan_zero   = (scan_reg == '0);
        stat.goes_before = (cur_reg.f < rd_data_reg.f)
                         || ((cur_reg.f == rd_data_reg.f) && (cur_reg.h <= rd_data_reg.h));
        stat.out_free    = !out_valid_reg || rsp_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift)
            mem[wr_addr] <= rd_data_reg;
        else if (cmd.place)
            mem[wr_addr] <= cur_reg;
        if (cmd.rd_prev)
            rd_data_reg <= mem[prev_addr];
        else if (cmd.rd_head)
            rd_data_reg <= mem[head_reg];
    end

    // captured word and popped entry
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg        <= in_cmd;
            cur_reg.handle <= in_handle;
            cur_reg.f      <= in_f;
            cur_reg.h      <= in_h;
        end
        if (cmd.pop)
            pop_reg <= rd_data_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        if (cmd.place)
            count_next = count_reg + aopq_pkg::CNT_W'(1);
        else if (cmd.pop)
        begin
            count_next = count_reg - aopq_pkg::CNT_W'(1);
            head_next  = head_reg + aopq_pkg::PTR_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_res)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
            if (cmd.capture)
                scan_reg <= count_reg;
            else if (cmd.shift)
                scan_reg <= scan_dec;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.load_res)
        begin
            out_occ_reg <= count_reg;
            case (cmd.res_kind)
                aopq_pkg::RES_POP:
                begin
                    out_status_reg <= aopq_pkg::STAT_OK;
                    out_entry_reg  <= pop_reg;
                end
                aopq_pkg::RES_EMPTY:
                begin
                    out_status_reg <= aopq_pkg::STAT_EMPTY;
                    out_entry_reg  <= '0;
                end
                aopq_pkg::RES_FULL:
                begin
                    out_status_reg <= aopq_pkg::STAT_FULL;
                    out_entry_reg  <= '0;
                end
                default:
                begin
                    out_status_reg <= aopq_pkg::STAT_OK;
                    out_entry_reg  <= '0;
                end
            endcase
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = out_status_reg;
    assign rsp_handle = out_entry_reg.handle;
    assign rsp_f      = out_entry_reg.f;
    assign rsp_h      = out_entry_reg.h;
    assign rsp_occ    = out_occ_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= aopq_pkg::CNT_W'(aopq_pkg::QUEUE_DEPTH))
        else $error("occupancy beyond depth");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_prev || cmd.shift || cmd.place) |-> scan_reg <= count_reg)
        else $error("scan index beyond occupancy");
    a_place_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.place |-> !stat.full)
        else $error("placement into full store");
    a_shift_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |-> !stat.scan_zero)
        else $error("shift past the head");
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> count_reg == $past(count_reg) - aopq_pkg::CNT_W'(1))
        else $error("pop did not lower occupancy");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// self-checking bench for the open-list priority queue: a directed table, then random words,
// every reply checked against the table's typed reply or else a behavioural shadow of the sorted store
// depends on aopq_pkg, aopq_in_if, aopq_out_if and astar_open_list_priority_queue
module testbench;

    localparam int RANDOM_WORDS  = 1900;
    localparam int QUIET_WORDS   = 200;
    localparam int SETTLE_CYCLES = 4 + 2 * aopq_pkg::QUEUE_DEPTH + 16;

    typedef struct packed {
        aopq_pkg::status_t                status;
        logic [aopq_pkg::HANDLE_BITS-1:0] handle;
        logic [aopq_pkg::COST_BITS-1:0]   f;
        logic [aopq_pkg::COST_BITS-1:0]   h;
        logic [aopq_pkg::CNT_W-1:0]       occ;
    } reply_t;

    typedef struct packed {
        logic                             cmd;
        logic [aopq_pkg::HANDLE_BITS-1:0] handle;
        logic [aopq_pkg::COST_BITS-1:0]   f;
        logic [aopq_pkg::COST_BITS-1:0]   h;
        logic                             typed;
        reply_t                           reply;
    } row_t;

    typedef struct packed {
        logic   typed;
        reply_t reply;
    } note_t;

    localparam reply_t NO_REPLY = '{aopq_pkg::STAT_OK, 16'h0000, 10'h000, 10'h000, 7'd0};

    localparam row_t DIRECTED [21] = '{
        '{aopq_pkg::CMD_POP,    16'h0000, 10'h000, 10'h000, 1'b1,
          '{aopq_pkg::STAT_EMPTY, 16'h0000, 10'h000, 10'h000, 7'd0}},
        '{aopq_pkg::CMD_INSERT, 16'hffff, 10'h3ff, 10'h3ff, 1'b1,
          '{aopq_pkg::STAT_OK, 16'h0000, 10'h000, 10'h000, 7'd1}},
        '{aopq_pkg::CMD_INSERT, 16'h0000, 10'h000, 10'h000, 1'b1,
          '{aopq_pkg::STAT_OK, 16'h0000, 10'h000, 10'h000, 7'd2}},
        '{aopq_pkg::CMD_INSERT, 16'h1234, 10'h000, 10'h3ff, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_INSERT, 16'h5555, 10'h3ff, 10'h000, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_INSERT, 16'haaaa, 10'h000, 10'h000, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_INSERT, 16'h0f0f, 10'h200, 10'h1ff, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_INSERT, 16'hf0f0, 10'h200, 10'h1ff, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_INSERT, 16'h00ff, 10'h1ff, 10'h200, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_POP,    16'h0000, 10'h000, 10'h000, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_POP,    16'hffff, 10'h3ff, 10'h3ff, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_POP,    16'h0000, 10'h000, 10'h000, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_POP,    16'h0000, 10'h000, 10'h000, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_POP,    16'h0000, 10'h000, 10'h000, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_POP,    16'h0000, 10'h000, 10'h000, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_POP,    16'h0000, 10'h000, 10'h000, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_POP,    16'h0000, 10'h000, 10'h000, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_POP,    16'h0000, 10'h000, 10'h000, 1'b0, NO_REPLY},
        '{aopq_pkg::CMD_POP,    16'h0000, 10'h000, 10'h000, 1'b1,
          '{aopq_pkg::STAT_EMPTY, 16'h0000, 10'h000, 10'h000, 7'd0}},
        '{aopq_pkg::CMD_INSERT, 16'h8001, 10'h155, 10'h2aa, 1'b1,
          '{aopq_pkg::STAT_OK, 16'h0000, 10'h000, 10'h000, 7'd1}},
        '{aopq_pkg::CMD_POP,    16'h0000, 10'h000, 10'h000, 1'b1,
          '{aopq_pkg::STAT_OK, 16'h8001, 10'h155, 10'h2aa, 7'd0}}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   errors = 0;
    bit   no_idle = 1'b0;

    aopq_pkg::entry_t shadow_list [aopq_pkg::QUEUE_DEPTH];
    int               shadow_count = 0;
    reply_t           due_replies [$];
    note_t            typed_notes [$];

    aopq_in_if  req ();
    aopq_out_if rsp ();

    astar_open_list_priority_queue i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    function automatic reply_t open_list_step(
        input logic                             cmd,
        input logic [aopq_pkg::HANDLE_BITS-1:0] handle,
        input logic [aopq_pkg::COST_BITS-1:0]   f,
        input logic [aopq_pkg::COST_BITS-1:0]   h);
        reply_t r;
        int     pos;
        int     i;
        r = NO_REPLY;
        if (cmd == aopq_pkg::CMD_INSERT)
        begin
            if (shadow_count == aopq_pkg::QUEUE_DEPTH)
            begin
                r.status = aopq_pkg::STAT_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < shadow_count && !(f < shadow_list[pos].f ||
                       (f == shadow_list[pos].f && h <= shadow_list[pos].h)))
                    pos++;
                for (i = shadow_count; i > pos; i--)
                    shadow_list[i] = shadow_list[i-1];
                shadow_list[pos] = '{handle, f, h};
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                r.status = aopq_pkg::STAT_EMPTY;
            end
            else
            begin
                r.handle = shadow_list[0].handle;
                r.f      = shadow_list[0].f;
                r.h      = shadow_list[0].h;
                for (i = 0; i < shadow_count - 1; i++)
                    shadow_list[i] = shadow_list[i+1];
                shadow_count--;
            end
        end
        r.occ = aopq_pkg::CNT_W'(shadow_count);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // replies are checked before the new word is modelled; latency keeps them apart
    always @(posedge clk)
    begin
        reply_t want;
        reply_t got;
        note_t  note;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{aopq_pkg::status_t'(rsp.status), rsp.out_handle, rsp.out_total_cost,
                        rsp.out_heuristic, rsp.occupancy};
                if (due_replies.size() == 0)
                begin
                    $display("%0t: reply with none due, expected nothing, actual %h",
                             $time, got);
                    errors++;
                end
                else
                begin
                    want = due_replies.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("out_handle", want.handle, got.handle);
                    check_field("out_total_cost", want.f, got.f);
                    check_field("out_heuristic", want.h, got.h);
                    check_field("occupancy", want.occ, got.occ);
                end
            end
            if (req.valid && req.ready)
            begin
                want = open_list_step(req.cmd, req.entry_handle, req.total_cost,
                                      req.heuristic_cost);
                note = typed_notes.pop_front();
                due_replies.push_back(note.typed ? note.reply : want);
            end
        end
    end

    task automatic send_word(input logic cmd,
                             input logic [aopq_pkg::HANDLE_BITS-1:0] handle,
                             input logic [aopq_pkg::COST_BITS-1:0] f,
                             input logic [aopq_pkg::COST_BITS-1:0] h,
                             input logic typed, input reply_t reply, input bit gappy);
        note_t note;
        note.typed = typed;
        note.reply = reply;
        typed_notes.push_back(note);
        req.valid          <= 1'b1;
        req.cmd            <= cmd;
        req.entry_handle   <= handle;
        req.total_cost     <= f;
        req.heuristic_cost <= h;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (gappy && $urandom_range(0, 5) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        while (due_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [aopq_pkg::COST_BITS-1:0] pick_cost(input int mode);
        case (mode)
            1:       return aopq_pkg::COST_BITS'($urandom_range(0, 7));
            2:       return aopq_pkg::COST_BITS'($urandom_range(1016, 1023));
            default: return aopq_pkg::COST_BITS'($urandom_range(0, 1023));
        endcase
    endfunction

    initial
    begin
        rsp.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (no_idle || $urandom_range(0, 2) != 0)
            begin
                rsp.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int words;
        int burst;
        int k;
        int pct_insert;
        int key_mode;
        int bias;
        bit gappy;
        bit is_insert;
        req.valid          <= 1'b0;
        req.cmd            <= aopq_pkg::CMD_INSERT;
        req.entry_handle   <= '0;
        req.total_cost     <= '0;
        req.heuristic_cost <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < $size(DIRECTED); k++)
            send_word(DIRECTED[k].cmd, DIRECTED[k].handle, DIRECTED[k].f, DIRECTED[k].h,
                      DIRECTED[k].typed, DIRECTED[k].reply, 1'b1);
        wait_drained();

        // bursts biased to fill, drain or hold balance, so the full and empty edges recur
        words = 0;
        while (words < RANDOM_WORDS)
        begin
            bias       = $urandom_range(0, 9);
            pct_insert = (bias < 4) ? 95 : ((bias < 7) ? 10 : 55);
            key_mode   = $urandom_range(0, 3);
            burst      = $urandom_range(30, 100);
            gappy      = ($urandom_range(0, 3) != 0);
            for (k = 0; k < burst && words < RANDOM_WORDS; k++)
            begin
                if (words == RANDOM_WORDS / 2)
                    wait_drained();
                no_idle   = (words >= RANDOM_WORDS - QUIET_WORDS);
                is_insert = ($urandom_range(1, 100) <= pct_insert);
                send_word(is_insert ? aopq_pkg::CMD_INSERT : aopq_pkg::CMD_POP,
                          aopq_pkg::HANDLE_BITS'($urandom()),
                          pick_cost(key_mode), pick_cost(key_mode), 1'b0, NO_REPLY,
                          gappy && !no_idle);
                words++;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && due_replies.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
